@@ src/assert_macros.svh @@
// assertion macros used by the checker file edpq_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define EDPQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define EDPQ_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/edpq_pkg.sv @@
// types and constants for the encoder detent and press qualifier
// no dependencies
package edpq_pkg;

  localparam int CountW = 32;
  localparam int TimeW  = 32;
  localparam int HoldW  = 16;
  localparam int SubW   = 8;
  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 16;

  localparam logic [HoldW-1:0] HOLD_TIME_RST = 16'd400;
  localparam logic [SubW-1:0]  SUBSTEPS_RST  = 8'd2;

  localparam logic [CfgAddrW-1:0] REG_HOLD_TIME = 1'd0;
  localparam logic [CfgAddrW-1:0] REG_SUBSTEPS  = 1'd1;

  typedef struct packed {
    logic sel;
    logic back;
  } btn_evt_t;

endpackage

@@ src/encoder_detent_and_press_qualifier.sv @@
// top level: input register, detent and button logic, result register
// depends on edpq_pkg, edpq_detent, edpq_button
//
// Usage: one poll item per in_ handshake, one result item per poll on out_.
// in_tdata carries the encoder count, raw button level and ms timestamp,
// in_tuser the read-ok flag. out_tdata carries the detent step (-1/0/+1)
// and the select and back pulses.
// An accepted item passes through the input register, then the result
// register, before it is shown on out_. Throughput: one item per cycle
// while out_tready is high; residue and press state update as an item
// moves from the input register into the result register. The registers
// hold_time_ms and substeps_per_detent are written through cfg_we/cfg_addr/
// cfg_wdata; the user must write them only while the block is idle, and the block does not enforce it.
// Reset (rst_n low, synchronous) clears count, residue and press state,
// empties both registers and loads hold 400 ms and 2 counts per detent.
// When out_tready is low the result holds and one more item is taken into
// the input register; in_tready then drops until the result is taken.
module encoder_detent_and_press_qualifier
  import edpq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [71:0]         in_tdata,  // encoder_count[31:0], button_level[32], now_ms[64:33]
  input  logic [0:0]          in_tuser,  // read_ok[0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata  // detent_step[1:0], select_event[2], back_event[3]
);

  logic [HoldW-1:0]  hold_time_r;
  logic [SubW-1:0]   substeps_r;

  logic              in_vld_r;
  logic [CountW-1:0] count_r;
  logic              btn_lvl_r;
  logic [TimeW-1:0]  now_r;
  logic              ok_r;

  logic              out_vld_r;
  logic [1:0]        step_r;
  btn_evt_t          evt_r;

  logic              adv;
  logic              in_acc;
  logic signed [1:0] step;
  btn_evt_t          evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r <= HOLD_TIME_RST;
      substeps_r  <= SUBSTEPS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HOLD_TIME: hold_time_r <= cfg_wdata[HoldW-1:0];
        REG_SUBSTEPS:  substeps_r  <= cfg_wdata[SubW-1:0];
        default: ;
      endcase
    end
  end

  // item moves from the input register to the result register
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      count_r   <= in_tdata[31:0];
      btn_lvl_r <= in_tdata[32];
      now_r     <= in_tdata[64:33];
      ok_r      <= in_tuser[0];
    end
  end

  edpq_detent u_detent (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .read_ok       (ok_r),
    .encoder_count (count_r),
    .substeps      (substeps_r),
    .detent_step   (step)
  );

  edpq_button u_button (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .read_ok      (ok_r),
    .button_level (btn_lvl_r),
    .now_ms       (now_r),
    .hold_time    (hold_time_r),
    .evt          (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step_r <= step;
      evt_r  <= evt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, evt_r.back, evt_r.sel, step_r};

endmodule

@@ src/edpq_detent.sv @@
// count delta accumulation, saturating residue and detent step decision
// depends on edpq_pkg
module edpq_detent
  import edpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     read_ok,
  input  logic [CountW-1:0]        encoder_count,
  input  logic [SubW-1:0]          substeps,
  output logic signed [1:0]        detent_step
);

  logic [CountW-1:0]        last_count_r, last_count_nxt;
  logic                     count_seen_r, count_seen_nxt;
  logic signed [CountW-1:0] residue_r, residue_nxt;

  logic [CountW-1:0]        delta;
  logic signed [CountW:0]   sum;
  logic signed [CountW-1:0] res_mid;
  logic signed [CountW-1:0] size_s;
  logic [SubW-1:0]          size;

  always_comb begin
    delta = encoder_count - last_count_r;
    sum   = $signed({residue_r[CountW-1], residue_r}) + $signed({delta[CountW-1], delta});
    // saturate to the signed 32-bit range
    if (sum[CountW] != sum[CountW-1]) begin
      res_mid = sum[CountW] ? {1'b1, {(CountW-1){1'b0}}} : {1'b0, {(CountW-1){1'b1}}};
    end else begin
      res_mid = sum[CountW-1:0];
    end
    if (!read_ok || !count_seen_r) begin
      res_mid = residue_r;
    end

    last_count_nxt = read_ok ? encoder_count : last_count_r;
    count_seen_nxt = count_seen_r | read_ok;

    size   = (substeps == '0) ? SubW'(1) : substeps;
    size_s = $signed({{(CountW-SubW){1'b0}}, size});

    detent_step = 2'sd0;
    residue_nxt = res_mid;
    if (res_mid >= size_s) begin
      detent_step = 2'sd1;
      residue_nxt = res_mid - size_s;
    end else if (res_mid <= -size_s) begin
      detent_step = -2'sd1;
      residue_nxt = res_mid + size_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      count_seen_r <= 1'b0;
      residue_r    <= '0;
    end else if (adv) begin
      last_count_r <= last_count_nxt;
      count_seen_r <= count_seen_nxt;
      residue_r    <= residue_nxt;
    end
  end

endmodule

@@ src/edpq_button.sv @@
// button press tracker with hold qualification on wrapping ms timestamps
// depends on edpq_pkg
module edpq_button
  import edpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             read_ok,
  input  logic             button_level,
  input  logic [TimeW-1:0] now_ms,
  input  logic [HoldW-1:0] hold_time,
  output btn_evt_t         evt
);

  logic             active_r, active_nxt;
  logic             long_r, long_nxt;
  logic [TimeW-1:0] start_r, start_nxt;
  logic             pressed;
  logic [TimeW-1:0] held;

  always_comb begin
    pressed    = ~button_level;
    held       = now_ms - start_r;
    active_nxt = active_r;
    long_nxt   = long_r;
    start_nxt  = start_r;
    evt        = '0;
    if (read_ok) begin
      if (pressed && !active_r) begin
        active_nxt = 1'b1;
        long_nxt   = 1'b0;
        start_nxt  = now_ms;
      end else if (pressed && !long_r && held >= {{(TimeW-HoldW){1'b0}}, hold_time}) begin
        long_nxt = 1'b1;
      end else if (!pressed && active_r) begin
        evt.back   = long_r;
        evt.sel    = ~long_r;
        active_nxt = 1'b0;
        long_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      long_r   <= 1'b0;
      start_r  <= '0;
    end else if (adv) begin
      active_r <= active_nxt;
      long_r   <= long_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

@@ src/edpq_checker.sv @@
// port-level checks for encoder_detent_and_press_qualifier, bound to the top
// depends on assert_macros.svh
`include "assert_macros.svh"

module edpq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result stays put
  `EDPQ_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  // one release gives select or back, never both
  `EDPQ_ASSERT(a_one_event, clk, rst_n, out_tvalid |-> !(out_tdata[2] && out_tdata[3]), "select and back in one item")
  // step code and padding stay legal
  `EDPQ_ASSERT(a_step_code, clk, rst_n, out_tvalid |-> (out_tdata[1:0] != 2'b10) && (out_tdata[7:4] == 4'b0000), "illegal step code or padding")
  // nothing is shown right after reset
  `EDPQ_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind encoder_detent_and_press_qualifier edpq_checker u_edpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
